// ===== sv/mrr_pkg.sv =====
// Shared types, constants and helpers for the matrix ring rotation remap block.
package mrr_pkg;

   localparam int MAX_DIM    = 256;
   localparam int DIM_W      = 9;
   localparam int COORD_W    = 8;
   localparam int RING_W     = 7;
   localparam int LEN_W      = 10;
   localparam int VALUE_W    = 32;
   localparam int ROT_W      = 30;
   localparam int MOD_BITS   = 3;
   localparam int MOD_STAGES = ROT_W / MOD_BITS;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATION_COUNT = 2'd2;

   localparam logic [DIM_W-1:0] DIM_MIN   = 9'd2;
   localparam logic [DIM_W-1:0] DIM_MAX   = 9'(MAX_DIM);
   localparam logic [DIM_W-1:0] DIM_RESET = 9'd2;

   typedef struct packed {
      logic                      active;
      logic [COORD_W-1:0]        row;
      logic [COORD_W-1:0]        col;
      logic [RING_W-1:0]         ring;
      logic [DIM_W-1:0]          h;
      logic [DIM_W-1:0]          w;
      logic [LEN_W-1:0]          len;
      logic [LEN_W-1:0]          pos;
      logic [LEN_W-1:0]          rem;
      logic signed [VALUE_W-1:0] value;
   } item_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v < DIM_MIN) r = DIM_MIN;
      else if (v > DIM_MAX) r = DIM_MAX;
      return r;
   endfunction

endpackage

// ===== sv/mrr_front.sv =====
// Ring classification and position along the ring: two register stages.
module mrr_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [mrr_pkg::COORD_W-1:0]         src_row,
   input  logic [mrr_pkg::COORD_W-1:0]         src_col,
   input  logic signed [mrr_pkg::VALUE_W-1:0]  elem_value,
   input  logic [mrr_pkg::DIM_W-1:0]           rows,
   input  logic [mrr_pkg::DIM_W-1:0]           cols,
   output logic                                out_valid,
   output mrr_pkg::item_type                   out_item
);

   // stage A: distances to the edges
   logic                               a_valid_ff, a_valid_in;
   logic [mrr_pkg::COORD_W-1:0]        a_row_ff, a_col_ff;
   logic signed [mrr_pkg::VALUE_W-1:0] a_value_ff;
   logic                               a_inside_ff, a_inside_in;
   logic [mrr_pkg::RING_W-1:0]         a_ring_ff, a_ring_in;

   logic [mrr_pkg::DIM_W-1:0] d_top, d_left, d_bot, d_right, d_min0, d_min1, d_min;

   always_comb begin
      d_top   = {1'b0, src_row};
      d_left  = {1'b0, src_col};
      d_bot   = rows - 9'd1 - d_top;
      d_right = cols - 9'd1 - d_left;
      d_min0  = (d_top < d_left) ? d_top : d_left;
      d_min1  = (d_bot < d_right) ? d_bot : d_right;
      d_min   = (d_min0 < d_min1) ? d_min0 : d_min1;
      a_inside_in = (d_top < rows) && (d_left < cols);
      // inside the matrix the ring index never exceeds 127
      a_ring_in   = d_min[mrr_pkg::RING_W-1:0];
      a_valid_in  = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= a_valid_in;
      end
      if (en) begin
         a_row_ff    <= src_row;
         a_col_ff    <= src_col;
         a_value_ff  <= elem_value;
         a_inside_ff <= a_inside_in;
         a_ring_ff   <= a_ring_in;
      end
   end

   // stage B: ring geometry and walk position
   logic               b_valid_ff;
   mrr_pkg::item_type  b_item_ff, b_item_in;

   logic [mrr_pkg::DIM_W-1:0]   k9, k2, half, dmin, h, w, hm1, wm1;
   logic [mrr_pkg::COORD_W-1:0] i, j;
   logic [mrr_pkg::LEN_W-1:0]   hw, len, p;

   always_comb begin
      k9   = {2'b00, a_ring_ff};
      k2   = {1'b0, a_ring_ff, 1'b0};
      dmin = (rows < cols) ? rows : cols;
      half = dmin >> 1;
      h    = rows - k2;
      w    = cols - k2;
      hm1  = h - 9'd1;
      wm1  = w - 9'd1;
      hw   = {1'b0, h} + {1'b0, w};
      len  = {hw[mrr_pkg::LEN_W-2:0], 1'b0} - 10'd4;
      i    = a_row_ff - {1'b0, a_ring_ff};
      j    = a_col_ff - {1'b0, a_ring_ff};
      if (i == 8'd0)
         p = {2'b00, j};
      else if ({1'b0, j} == wm1)
         p = {1'b0, wm1} + {2'b00, i};
      else if ({1'b0, i} == hm1)
         p = {1'b0, wm1} + {1'b0, hm1} + {1'b0, wm1} - {2'b00, j};
      else
         p = {wm1, 1'b0} + {1'b0, hm1} + {1'b0, hm1} - {2'b00, i};

      b_item_in.active = a_inside_ff && (k9 < half);
      b_item_in.row    = a_row_ff;
      b_item_in.col    = a_col_ff;
      b_item_in.ring   = a_ring_ff;
      b_item_in.h      = h;
      b_item_in.w      = w;
      b_item_in.len    = len;
      b_item_in.pos    = p;
      b_item_in.rem    = '0;
      b_item_in.value  = a_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
      if (en) begin
         b_item_ff <= b_item_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

endmodule

// ===== sv/mrr_mod_stage.sv =====
// One stage of the pipelined remainder of the rotation count by the ring length.
module mrr_mod_stage (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  mrr_pkg::item_type                in_item,
   input  logic [mrr_pkg::MOD_BITS-1:0]     rot_bits,
   output logic                             out_valid,
   output mrr_pkg::item_type                out_item
);

   logic              valid_ff;
   mrr_pkg::item_type item_ff, item_in;

   logic [mrr_pkg::LEN_W:0]   trial;
   logic [mrr_pkg::LEN_W-1:0] rem;

   always_comb begin
      item_in = in_item;
      rem     = in_item.rem;
      trial   = '0;
      // shift in one count bit, subtract the length when it fits
      for (int t = 0; t < mrr_pkg::MOD_BITS; t++) begin
         trial = {rem, rot_bits[mrr_pkg::MOD_BITS-1-t]};
         if (trial >= {1'b0, in_item.len})
            trial = trial - {1'b0, in_item.len};
         rem = trial[mrr_pkg::LEN_W-1:0];
      end
      item_in.rem = rem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== sv/mrr_back.sv =====
// Position step-back and mapping to the destination row and column: two register stages.
module mrr_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  mrr_pkg::item_type                   in_item,
   output logic                                out_valid,
   output logic [mrr_pkg::COORD_W-1:0]         dst_row,
   output logic [mrr_pkg::COORD_W-1:0]         dst_col,
   output logic signed [mrr_pkg::VALUE_W-1:0]  out_value
);

   // stage C: new position along the ring
   logic              c_valid_ff;
   mrr_pkg::item_type c_item_ff, c_item_in;
   logic [mrr_pkg::LEN_W:0] wrap;

   always_comb begin
      c_item_in = in_item;
      wrap = {1'b0, in_item.pos} + {1'b0, in_item.len} - {1'b0, in_item.rem};
      if (in_item.pos >= in_item.rem)
         c_item_in.pos = in_item.pos - in_item.rem;
      else
         c_item_in.pos = wrap[mrr_pkg::LEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= in_valid;
      end
      if (en) begin
         c_item_ff <= c_item_in;
      end
   end

   // output stage: walk position back to coordinates
   logic                               out_valid_ff;
   logic [mrr_pkg::COORD_W-1:0]        dst_row_ff, dst_row_in, dst_col_ff, dst_col_in;
   logic signed [mrr_pkg::VALUE_W-1:0] out_value_ff;

   logic [mrr_pkg::LEN_W-1:0] q, wm1, hm1, edge_r, edge_b, i, j, k, dr, dc;

   always_comb begin
      q      = c_item_ff.pos;
      k      = {3'b000, c_item_ff.ring};
      wm1    = {1'b0, c_item_ff.w} - 10'd1;
      hm1    = {1'b0, c_item_ff.h} - 10'd1;
      edge_r = wm1 + hm1;
      edge_b = edge_r + wm1;
      if (q <= wm1) begin
         i = '0;
         j = q;
      end else if (q <= edge_r) begin
         i = q - wm1;
         j = wm1;
      end else if (q <= edge_b) begin
         i = hm1;
         j = wm1 - (q - edge_r);
      end else begin
         i = hm1 - (q - edge_b);
         j = '0;
      end
      dr = i + k;
      dc = j + k;
      if (c_item_ff.active) begin
         dst_row_in = dr[mrr_pkg::COORD_W-1:0];
         dst_col_in = dc[mrr_pkg::COORD_W-1:0];
      end else begin
         dst_row_in = c_item_ff.row;
         dst_col_in = c_item_ff.col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= c_valid_ff;
      end
      if (en) begin
         dst_row_ff   <= dst_row_in;
         dst_col_ff   <= dst_col_in;
         out_value_ff <= c_item_ff.value;
      end
   end

   assign out_valid = out_valid_ff;
   assign dst_row   = dst_row_ff;
   assign dst_col   = dst_col_ff;
   assign out_value = out_value_ff;

endmodule

// ===== sv/matrix_ring_rotation_remap_top.sv =====
// Throughput: one element per cycle unless a result waits on rsp_ready; the 10-stage
// remainder chain (3 count bits a stage) sets the depth.
// The whole pipeline holds while a result waits on rsp_ready.
// Reset: synchronous, clears all valid bits and loads row_count = 2, col_count = 2,
// rotation_count = 0; no memory, so no clearing pass.
module matrix_ring_rotation_remap_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [mrr_pkg::COORD_W-1:0]           req_src_row,
   input  logic [mrr_pkg::COORD_W-1:0]           req_src_col,
   input  logic signed [mrr_pkg::VALUE_W-1:0]    req_elem_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [mrr_pkg::COORD_W-1:0]           rsp_dst_row,
   output logic [mrr_pkg::COORD_W-1:0]           rsp_dst_col,
   output logic signed [mrr_pkg::VALUE_W-1:0]    rsp_out_value,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mrr_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mrr_pkg::ROT_W-1:0]             csr_wdata
);

   logic [mrr_pkg::DIM_W-1:0] row_count_ff, col_count_ff, rows, cols;
   logic [mrr_pkg::ROT_W-1:0] rotation_count_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff      <= mrr_pkg::DIM_RESET;
         col_count_ff      <= mrr_pkg::DIM_RESET;
         rotation_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mrr_pkg::CSR_ROW_COUNT:      row_count_ff <= csr_wdata[mrr_pkg::DIM_W-1:0];
            mrr_pkg::CSR_COL_COUNT:      col_count_ff <= csr_wdata[mrr_pkg::DIM_W-1:0];
            mrr_pkg::CSR_ROTATION_COUNT: rotation_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rows = mrr_pkg::clamp_dim(row_count_ff);
   assign cols = mrr_pkg::clamp_dim(col_count_ff);

   // advance every stage unless the output register holds an untaken result
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   logic              mod_valid [mrr_pkg::MOD_STAGES+1];
   mrr_pkg::item_type mod_item  [mrr_pkg::MOD_STAGES+1];

   mrr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_valid),
      .src_row    (req_src_row),
      .src_col    (req_src_col),
      .elem_value (req_elem_value),
      .rows       (rows),
      .cols       (cols),
      .out_valid  (mod_valid[0]),
      .out_item   (mod_item[0])
   );

   for (genvar s = 0; s < mrr_pkg::MOD_STAGES; s++) begin : g_mod
      mrr_mod_stage u_mod (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (mod_valid[s]),
         .in_item   (mod_item[s]),
         .rot_bits  (rotation_count_ff[mrr_pkg::ROT_W-1-mrr_pkg::MOD_BITS*s -: mrr_pkg::MOD_BITS]),
         .out_valid (mod_valid[s+1]),
         .out_item  (mod_item[s+1])
      );
   end

   mrr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mod_valid[mrr_pkg::MOD_STAGES]),
      .in_item   (mod_item[mrr_pkg::MOD_STAGES]),
      .out_valid (rsp_valid),
      .dst_row   (rsp_dst_row),
      .dst_col   (rsp_dst_col),
      .out_value (rsp_out_value)
   );

endmodule

// ===== sv/mrr_checker.sv =====
// Port-level checks for the ring rotation remap block, bound to the top level.
module mrr_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [mrr_pkg::COORD_W-1:0]           rsp_dst_row,
   input logic [mrr_pkg::COORD_W-1:0]           rsp_dst_col,
   input logic signed [mrr_pkg::VALUE_W-1:0]    rsp_out_value
);

   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_dst_row) && $stable(rsp_dst_col)
                                  && $stable(rsp_out_value))
      else $error("rsp payload changed while stalled");

   // input side stalls exactly when a result waits
   assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow the output stall");

   // nothing emerges straight after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind matrix_ring_rotation_remap_top mrr_checker u_mrr_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the matrix ring rotation remap block.
module tb_top;

   typedef logic [mrr_pkg::COORD_W-1:0] coord_type;
   typedef logic [mrr_pkg::ROT_W-1:0]   word_type;
   typedef logic [mrr_pkg::DIM_W-1:0]   dim_type;

   localparam logic [mrr_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;  // unmapped index; writes are dropped
   localparam int CSR_COUNT     = 3;
   localparam int DIM_CAP       = (mrr_pkg::MAX_DIM < 256) ? mrr_pkg::MAX_DIM : 256;
   localparam int PIPE_DEPTH    = 14;
   localparam int SETTLE_CYCLES = PIPE_DEPTH + 6;
   localparam int STALL_LIMIT   = 2000;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 125;
   localparam int PRINT_CAP     = 30;

   typedef enum int {LAND_OUTSIDE, LAND_CENTRE, LAND_RING} landing_kind_type;

   typedef struct {
      logic [mrr_pkg::COORD_W-1:0]        row;
      logic [mrr_pkg::COORD_W-1:0]        col;
      logic signed [mrr_pkg::VALUE_W-1:0] value;
   } element_type;

   logic                               clock          = 1'b0;
   logic                               reset          = 1'b1;
   logic                               req_valid      = 1'b0;
   logic                               req_ready;
   logic [mrr_pkg::COORD_W-1:0]        req_src_row    = '0;
   logic [mrr_pkg::COORD_W-1:0]        req_src_col    = '0;
   logic signed [mrr_pkg::VALUE_W-1:0] req_elem_value = '0;
   logic                               rsp_valid;
   logic                               rsp_ready      = 1'b0;
   logic [mrr_pkg::COORD_W-1:0]        rsp_dst_row;
   logic [mrr_pkg::COORD_W-1:0]        rsp_dst_col;
   logic signed [mrr_pkg::VALUE_W-1:0] rsp_out_value;
   logic                               csr_valid      = 1'b0;
   logic                               csr_ready;
   logic [mrr_pkg::CSR_IDX_W-1:0]      csr_index      = '0;
   logic [mrr_pkg::ROT_W-1:0]          csr_wdata      = '0;

   // shadow copy of the block's registers
   logic [mrr_pkg::DIM_W-1:0] rows_reg  = mrr_pkg::DIM_RESET;
   logic [mrr_pkg::DIM_W-1:0] cols_reg  = mrr_pkg::DIM_RESET;
   logic [mrr_pkg::ROT_W-1:0] turns_reg = '0;

   element_type pending_q[$];
   element_type landing_q[$];

   int  gap_left       = 0;
   int  stall_left     = 0;
   int  tx_idle_pct    = 0;
   int  rx_stall_pct   = 0;
   bit  long_hold_wish = 1'b0;
   bit  long_hold_done = 1'b0;
   int  n_queued       = 0;
   int  n_accepted     = 0;
   int  n_results      = 0;
   int  n_checked      = 0;
   int  n_errors       = 0;
   int  n_reg_writes   = 0;
   int  kind_count[3]  = '{default: 0};

   matrix_ring_rotation_remap_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_src_row    (req_src_row),
      .req_src_col    (req_src_col),
      .req_elem_value (req_elem_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_dst_row    (rsp_dst_row),
      .rsp_dst_col    (rsp_dst_col),
      .rsp_out_value  (rsp_out_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic flag_mismatch(input string what);
      if (n_errors < PRINT_CAP) $display("MISMATCH @%0t: %s", $time, what);
      n_errors++;
   endtask

   function automatic int unsigned clip_dim(input logic [mrr_pkg::DIM_W-1:0] raw);
      if (raw < 2) return 2;
      if (raw > DIM_CAP) return DIM_CAP;
      return raw;
   endfunction

   // Landing place of one element under the current shadow registers.
   function automatic landing_kind_type ring_landing(
         input  logic [mrr_pkg::COORD_W-1:0] src_r,
         input  logic [mrr_pkg::COORD_W-1:0] src_c,
         output logic [mrr_pkg::COORD_W-1:0] dst_r,
         output logic [mrr_pkg::COORD_W-1:0] dst_c);
      int unsigned rows, cols, r, c, k, h, w, len, i, j, p, q;
      rows  = clip_dim(rows_reg);
      cols  = clip_dim(cols_reg);
      r     = src_r;
      c     = src_c;
      dst_r = src_r;
      dst_c = src_c;
      if (r >= rows || c >= cols) return LAND_OUTSIDE;
      k = (r < c) ? r : c;
      if (rows - 1 - r < k) k = rows - 1 - r;
      if (cols - 1 - c < k) k = cols - 1 - c;
      if (k >= ((rows < cols) ? rows : cols) / 2) return LAND_CENTRE;
      h   = rows - 2 * k;
      w   = cols - 2 * k;
      len = 2 * (h + w) - 4;
      i   = r - k;
      j   = c - k;
      // walk: top row rightwards, right column down, bottom row leftwards, left column up
      if (i == 0) p = j;
      else if (j == w - 1) p = (w - 1) + i;
      else if (i == h - 1) p = (w - 1) + (h - 1) + (w - 1 - j);
      else p = 2 * (w - 1) + (h - 1) + (h - 1 - i);
      q = (p + len - turns_reg % len) % len;
      if (q <= w - 1) begin
         i = 0;
         j = q;
      end else if (q <= w + h - 2) begin
         i = q - (w - 1);
         j = w - 1;
      end else if (q <= 2 * w + h - 3) begin
         i = h - 1;
         j = (w - 1) - (q - (w + h - 2));
      end else begin
         i = (h - 1) - (q - (2 * w + h - 3));
         j = 0;
      end
      dst_r = coord_type'(i + k);
      dst_c = coord_type'(j + k);
      return LAND_RING;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int draw_gap(input int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(40, 8);
      return $urandom_range(3, 1);
   endfunction

   // Element driver: present queued elements, hold each until its transfer.
   always @(posedge clock) begin
      element_type      nxt;
      element_type      land;
      landing_kind_type kind;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            kind       = ring_landing(req_src_row, req_src_col, land.row, land.col);
            land.value = req_elem_value;
            landing_q  = {landing_q, land};
            kind_count[kind]++;
            n_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               nxt = pending_q.pop_front();
               req_valid      <= 1'b1;
               req_src_row    <= nxt.row;
               req_src_col    <= nxt.col;
               req_elem_value <= nxt.value;
               gap_left = draw_gap(tx_idle_pct);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each transfer with the oldest landing place.
   always @(posedge clock) begin
      element_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_results++;
            if (landing_q.size() == 0) begin
               flag_mismatch($sformatf("result with nothing pending: row %0d col %0d value %0d",
                                       rsp_dst_row, rsp_dst_col, rsp_out_value));
            end else begin
               want = landing_q.pop_front();
               n_checked++;
               if (rsp_dst_row !== want.row)
                  flag_mismatch($sformatf("dst_row got %0d want %0d", rsp_dst_row, want.row));
               if (rsp_dst_col !== want.col)
                  flag_mismatch($sformatf("dst_col got %0d want %0d", rsp_dst_col, want.col));
               if (rsp_out_value !== want.value)
                  flag_mismatch($sformatf("out_value got %0d want %0d",
                                          rsp_out_value, want.value));
            end
         end
         if (long_hold_wish && !long_hold_done) begin
            long_hold_done = 1'b1;
            stall_left     = LONG_HOLD;
         end else if (stall_left == 0) begin
            stall_left = draw_gap(rx_stall_pct);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("tb_top NOT OK");
      $finish;
   end

   task automatic write_csr(input logic [mrr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [mrr_pkg::ROT_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         mrr_pkg::CSR_ROW_COUNT:      rows_reg  = data[mrr_pkg::DIM_W-1:0];
         mrr_pkg::CSR_COL_COUNT:      cols_reg  = data[mrr_pkg::DIM_W-1:0];
         mrr_pkg::CSR_ROTATION_COUNT: turns_reg = data;
         default: ;
      endcase
      n_reg_writes++;
   endtask

   task automatic queue_element(input int r, input int c,
                                input logic [mrr_pkg::VALUE_W-1:0] v);
      element_type e;
      e.row     = coord_type'(r);
      e.col     = coord_type'(c);
      e.value   = v;
      pending_q = {pending_q, e};
      n_queued++;
   endtask

   // wait for every queued element to come back, then let the pipeline settle
   task automatic drain();
      while (n_results < n_queued) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [mrr_pkg::ROT_W-1:0] random_dim_word();
      logic [mrr_pkg::ROT_W-1:0] word;
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: word = word_type'($urandom_range(12, 2));
         6:                word = word_type'($urandom_range(64, 13));
         7:                word = $urandom_range(1) ? word_type'(2) : word_type'(256);
         8:                word = word_type'($urandom_range(255, 2));
         default:          word = $urandom_range(1) ? word_type'($urandom_range(1))
                                                    : word_type'($urandom_range(511, 257));
      endcase
      // upper bits beyond the register width must be dropped
      if ($urandom_range(3) == 0)
         word[mrr_pkg::ROT_W-1:mrr_pkg::DIM_W] = word_type'($urandom()) >> mrr_pkg::DIM_W;
      return word;
   endfunction

   function automatic logic [mrr_pkg::ROT_W-1:0] random_turns();
      case ($urandom_range(7))
         0:       return '0;
         1:       return word_type'($urandom_range(3, 1));
         2, 3, 4: return word_type'($urandom_range(200));
         5:       return word_type'($urandom());
         6:       return '1;
         default: return word_type'($urandom_range(1000000000, 999000000));
      endcase
   endfunction

   task automatic random_setting();
      logic [mrr_pkg::CSR_IDX_W-1:0] order [CSR_COUNT];
      logic [mrr_pkg::CSR_IDX_W-1:0] idx;
      int                            first;
      order = '{mrr_pkg::CSR_ROW_COUNT, mrr_pkg::CSR_COL_COUNT, mrr_pkg::CSR_ROTATION_COUNT};
      first = $urandom_range(CSR_COUNT - 1);
      if ($urandom_range(3) == 0) write_csr(CSR_SPARE, word_type'($urandom()));
      for (int n = 0; n < CSR_COUNT; n++) begin
         idx = order[(first + n) % CSR_COUNT];
         if ($urandom_range(4) != 0)
            write_csr(idx, (idx == mrr_pkg::CSR_ROTATION_COUNT) ? random_turns()
                                                                 : random_dim_word());
      end
   endtask

   task automatic queue_random_elements(input int count);
      int unsigned                        rows, cols;
      logic [mrr_pkg::COORD_W-1:0]        r, c;
      logic signed [mrr_pkg::VALUE_W-1:0] v;
      rows = clip_dim(rows_reg);
      cols = clip_dim(cols_reg);
      repeat (count) begin
         if ($urandom_range(99) < 85) begin
            r = coord_type'($urandom_range(rows - 1));
            c = coord_type'($urandom_range(cols - 1));
         end else begin
            r = coord_type'($urandom_range(255));
            c = coord_type'($urandom_range(255));
         end
         v = $urandom();
         if ($urandom_range(15) == 0) v = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         queue_element(r, c, v);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // registers at their reset values: 2x2, no rotation
      queue_element(0, 0, 32'h7FFF_FFFF);
      queue_element(0, 1, 32'h8000_0000);
      queue_element(1, 1, 32'hFFFF_FFFF);
      queue_element(1, 0, 32'h0000_0000);
      queue_element(255, 255, 32'h5A5A_5A5A);
      drain();

      // odd row count leaves a centre line; the spare index must be ignored
      write_csr(mrr_pkg::CSR_ROW_COUNT, word_type'(5));
      write_csr(mrr_pkg::CSR_COL_COUNT, word_type'(6));
      write_csr(mrr_pkg::CSR_ROTATION_COUNT, word_type'(7));
      write_csr(CSR_SPARE, '1);
      queue_element(0, 0, 32'h8000_0000);
      queue_element(0, 5, 32'h7FFF_FFFF);
      queue_element(4, 5, 32'hFFFF_FFFF);
      queue_element(4, 0, 32'h0000_0001);
      queue_element(2, 2, 32'h1234_5678);
      queue_element(2, 3, 32'h8765_4321);
      queue_element(1, 1, 32'hA5A5_A5A5);
      queue_element(3, 4, 32'h0F0F_0F0F);
      queue_element(5, 0, 32'hDEAD_BEEF);
      queue_element(0, 6, 32'hCAFE_F00D);
      drain();

      // oversize rows clip to the cap, zero columns to the minimum, full-width count
      write_csr(mrr_pkg::CSR_ROW_COUNT, '1);
      write_csr(mrr_pkg::CSR_COL_COUNT, '0);
      write_csr(mrr_pkg::CSR_ROTATION_COUNT, '1);
      queue_element(0, 0, 32'h0000_00FF);
      queue_element(255, 1, 32'hFF00_0000);
      queue_element(128, 0, 32'h00FF_FF00);
      queue_element(0, 2, 32'h7FFF_FFFF);
      drain();

      write_csr(mrr_pkg::CSR_ROW_COUNT, word_type'(1));
      write_csr(mrr_pkg::CSR_COL_COUNT, word_type'(256));
      write_csr(mrr_pkg::CSR_ROTATION_COUNT, word_type'(1000000000));
      queue_element(0, 0, 32'h8000_0000);
      queue_element(1, 255, 32'h0000_0000);
      queue_element(0, 128, 32'hFFFF_FFFF);
      queue_element(2, 0, 32'h3333_3333);
      drain();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == RANDOM_PHASES - 1) begin
            write_csr(mrr_pkg::CSR_ROW_COUNT, word_type'(256));
            write_csr(mrr_pkg::CSR_COL_COUNT, word_type'(256));
            write_csr(mrr_pkg::CSR_ROTATION_COUNT, random_turns());
         end else if (ph == RANDOM_PHASES - 2) begin
            write_csr(mrr_pkg::CSR_ROW_COUNT, word_type'(2));
            write_csr(mrr_pkg::CSR_COL_COUNT, word_type'(2));
            write_csr(mrr_pkg::CSR_ROTATION_COUNT, word_type'($urandom_range(7)));
         end else begin
            random_setting();
         end
         case (ph % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 20; rx_stall_pct = 20; end
            2: begin tx_idle_pct = 50; rx_stall_pct = 10; end
            default: begin tx_idle_pct = 10; rx_stall_pct = 50; end
         endcase
         // back the pipeline up against a stalled receiver
         if (ph == 2) begin
            tx_idle_pct    = 0;
            long_hold_wish = 1'b1;
         end
         queue_random_elements(PHASE_ITEMS);
         drain();
      end

      if (landing_q.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", landing_q.size()));
      $display("Checked %0d of %0d elements over %0d register writes", n_checked, n_accepted,
               n_reg_writes);
      $display("Landings: %0d moved along a ring, %0d on a centre line, %0d outside the matrix",
               kind_count[LAND_RING], kind_count[LAND_CENTRE], kind_count[LAND_OUTSIDE]);
      if (n_errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/mrr_pkg.sv
sv/mrr_front.sv
sv/mrr_mod_stage.sv
sv/mrr_back.sv
sv/matrix_ring_rotation_remap_top.sv
sv/mrr_checker.sv
tb/sv/tb_top.sv
